FILE: hdl/mrr64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr64_pkg
// Types, constants and the shared add-compare-subtract step for the
// single-round strong probable prime tester.
// ----------------------------------------------------------------------------
package mrr64_pkg;

    localparam int CAND_W = 63;
    localparam int WIT_W  = 64;
    localparam int CNT_W  = 6;

    localparam logic [CAND_W-1:0] SMALL_LIMIT = CAND_W'(5);
    localparam logic [CAND_W-1:0] PRIME_TWO   = CAND_W'(2);
    localparam logic [CAND_W-1:0] PRIME_THREE = CAND_W'(3);
    localparam logic [CAND_W-1:0] VAL_ONE     = CAND_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SPLIT,
        S_POW,
        S_MUL,
        S_CHK,
        S_SQR,
        S_DONE
    } t_mrr_state;

    // Where a finished modular product is written back
    typedef enum logic [1:0] {
        TGT_ACC,
        TGT_BASE,
        TGT_SQR
    } t_mrr_tgt;

    // x < 2*m assumed: one conditional subtract brings x into 0..m-1
    function automatic logic [CAND_W-1:0] mod_fold(input logic [WIT_W-1:0] x,
                                                   input logic [CAND_W-1:0] m);
        logic [WIT_W-1:0] diff;
        diff = x - {1'b0, m};
        if (x >= {1'b0, m}) begin
            return diff[CAND_W-1:0];
        end else begin
            return x[CAND_W-1:0];
        end
    endfunction

endpackage

FILE: hdl/miller_rabin_round_64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_round_64
// One strong probable prime round on a 63-bit candidate with a raw witness.
// ----------------------------------------------------------------------------
// A transaction is taken when i_start is high and o_busy is low. The verdict
// appears on o_probable_prime for exactly one cycle with o_valid high; the
// receiver cannot stall it and must capture it in that cycle. Candidates below
// five go straight from idle to done. Otherwise the witness reduction runs one
// restoring step per witness bit, the split of candidate-1 shifts out one
// trailing zero per step, and each modular multiply runs one step per bit of
// its multiplier on the shared add-compare-subtract datapath. The
// exponentiation spends one sequencing step and one squaring per exponent bit
// plus one multiply per set bit; the squaring phase adds up to one multiply
// per trailing zero of candidate-1, which also shortens the exponent by one
// bit, so no more than about 126 multiplies run in total. A worst-case
// transaction is an even candidate near 2^63.
module miller_rabin_round_64 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [mrr64_pkg::CAND_W-1:0] i_candidate,
    input  logic [mrr64_pkg::WIT_W-1:0]  i_witness,
    output logic                         o_busy,
    output logic                         o_valid,
    output logic                         o_probable_prime
);

    mrr64_pkg::t_mrr_state r_state, n_state;
    mrr64_pkg::t_mrr_tgt   r_tgt;

    logic [mrr64_pkg::CAND_W-1:0] r_n;
    logic [mrr64_pkg::WIT_W-1:0]  r_wq;
    logic [mrr64_pkg::CAND_W-1:0] r_rem;
    logic [mrr64_pkg::CNT_W-1:0]  r_cnt;
    logic [mrr64_pkg::CAND_W-1:0] r_d;
    logic [mrr64_pkg::CNT_W-1:0]  r_s;
    logic [mrr64_pkg::CNT_W-1:0]  r_scnt;
    logic [mrr64_pkg::CAND_W-1:0] r_e;
    logic [mrr64_pkg::CAND_W-1:0] r_pacc;
    logic [mrr64_pkg::CAND_W-1:0] r_pbase;
    logic [mrr64_pkg::CAND_W-1:0] r_mx;
    logic [mrr64_pkg::CAND_W-1:0] r_my;
    logic [mrr64_pkg::CAND_W-1:0] r_macc;
    logic                         r_verdict;

    logic                         accept;
    logic                         small_cand;
    logic                         mul_done;
    logic [mrr64_pkg::CAND_W-1:0] div_m;
    logic [mrr64_pkg::CAND_W-1:0] n_rem;
    logic [mrr64_pkg::WIT_W-1:0]  acc_sum;
    logic [mrr64_pkg::CAND_W-1:0] n_macc;
    logic [mrr64_pkg::CAND_W-1:0] n_mx;
    logic [mrr64_pkg::CAND_W-1:0] n_minus1;

    assign accept     = i_start && (r_state == mrr64_pkg::S_IDLE);
    assign small_cand = i_candidate < mrr64_pkg::SMALL_LIMIT;
    assign mul_done   = (r_my == '0);
    assign div_m      = r_n - mrr64_pkg::PRIME_TWO;
    assign n_minus1   = r_n - mrr64_pkg::VAL_ONE;

    // Shared datapath: restoring divide step, or one shift-add multiply step
    assign n_rem   = mrr64_pkg::mod_fold({r_rem, r_wq[mrr64_pkg::WIT_W-1]}, div_m);
    assign acc_sum = {1'b0, r_macc} + (r_my[0] ? {1'b0, r_mx} : '0);
    assign n_macc  = mrr64_pkg::mod_fold(acc_sum, r_n);
    assign n_mx    = mrr64_pkg::mod_fold({r_mx, 1'b0}, r_n);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mrr64_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = small_cand ? mrr64_pkg::S_DONE : mrr64_pkg::S_DIV;
                end
            end
            mrr64_pkg::S_DIV: begin
                if (r_cnt == '1) begin
                    n_state = mrr64_pkg::S_SPLIT;
                end
            end
            mrr64_pkg::S_SPLIT: begin
                if (r_d[0]) begin
                    n_state = mrr64_pkg::S_POW;
                end
            end
            mrr64_pkg::S_POW: begin
                n_state = (r_e == '0) ? mrr64_pkg::S_CHK : mrr64_pkg::S_MUL;
            end
            mrr64_pkg::S_MUL: begin
                if (mul_done) begin
                    unique case (r_tgt)
                        mrr64_pkg::TGT_ACC:  n_state = mrr64_pkg::S_MUL;
                        mrr64_pkg::TGT_BASE: n_state = mrr64_pkg::S_POW;
                        mrr64_pkg::TGT_SQR: begin
                            n_state = (r_macc == mrr64_pkg::VAL_ONE) ?
                                      mrr64_pkg::S_DONE : mrr64_pkg::S_SQR;
                        end
                        default: n_state = mrr64_pkg::S_IDLE;
                    endcase
                end
            end
            mrr64_pkg::S_CHK: begin
                n_state = (r_pacc == mrr64_pkg::VAL_ONE) ?
                          mrr64_pkg::S_DONE : mrr64_pkg::S_SQR;
            end
            mrr64_pkg::S_SQR: begin
                n_state = (r_scnt == '0) ? mrr64_pkg::S_DONE : mrr64_pkg::S_MUL;
            end
            mrr64_pkg::S_DONE: begin
                n_state = mrr64_pkg::S_IDLE;
            end
            default: n_state = mrr64_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_busy           = (r_state != mrr64_pkg::S_IDLE);
        o_valid          = (r_state == mrr64_pkg::S_DONE);
        o_probable_prime = r_verdict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrr64_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mrr64_pkg::S_IDLE: begin
                if (accept) begin
                    r_n       <= i_candidate;
                    r_wq      <= i_witness;
                    r_rem     <= '0;
                    r_cnt     <= '0;
                    r_d       <= i_candidate - mrr64_pkg::VAL_ONE;
                    r_s       <= '0;
                    r_verdict <= small_cand && (i_candidate == mrr64_pkg::PRIME_TWO ||
                                                i_candidate == mrr64_pkg::PRIME_THREE);
                end
            end
            mrr64_pkg::S_DIV: begin
                r_rem   <= n_rem;
                r_wq    <= {r_wq[mrr64_pkg::WIT_W-2:0], 1'b0};
                r_cnt   <= r_cnt + 1'b1;
                r_pbase <= n_rem + mrr64_pkg::PRIME_TWO;
            end
            mrr64_pkg::S_SPLIT: begin
                if (r_d[0]) begin
                    r_pacc <= mrr64_pkg::VAL_ONE;
                    r_e    <= r_d;
                end else begin
                    r_d <= {1'b0, r_d[mrr64_pkg::CAND_W-1:1]};
                    r_s <= r_s + 1'b1;
                end
            end
            mrr64_pkg::S_POW: begin
                r_macc <= '0;
                if (r_e[0]) begin
                    r_mx  <= r_pacc;
                    r_my  <= r_pbase;
                    r_tgt <= mrr64_pkg::TGT_ACC;
                end else begin
                    r_mx  <= r_pbase;
                    r_my  <= r_pbase;
                    r_tgt <= mrr64_pkg::TGT_BASE;
                end
            end
            mrr64_pkg::S_MUL: begin
                if (mul_done) begin
                    unique case (r_tgt)
                        mrr64_pkg::TGT_ACC: begin
                            // chain straight into the base squaring
                            r_pacc <= r_macc;
                            r_mx   <= r_pbase;
                            r_my   <= r_pbase;
                            r_macc <= '0;
                            r_tgt  <= mrr64_pkg::TGT_BASE;
                        end
                        mrr64_pkg::TGT_BASE: begin
                            r_pbase <= r_macc;
                            r_e     <= {1'b0, r_e[mrr64_pkg::CAND_W-1:1]};
                        end
                        mrr64_pkg::TGT_SQR: begin
                            if (r_macc == mrr64_pkg::VAL_ONE) begin
                                r_verdict <= (r_pacc == n_minus1);
                            end else begin
                                r_pacc <= r_macc;
                            end
                        end
                        default: begin
                            r_pacc <= r_pacc;
                        end
                    endcase
                end else begin
                    r_macc <= n_macc;
                    r_mx   <= n_mx;
                    r_my   <= {1'b0, r_my[mrr64_pkg::CAND_W-1:1]};
                end
            end
            mrr64_pkg::S_CHK: begin
                r_scnt <= r_s;
                if (r_pacc == mrr64_pkg::VAL_ONE) begin
                    r_verdict <= 1'b1;
                end
            end
            mrr64_pkg::S_SQR: begin
                if (r_scnt == '0) begin
                    // no root of one found within s squarings
                    r_verdict <= 1'b0;
                end else begin
                    r_mx   <= r_pacc;
                    r_my   <= r_pacc;
                    r_macc <= '0;
                    r_tgt  <= mrr64_pkg::TGT_SQR;
                    r_scnt <= r_scnt - 1'b1;
                end
            end
            mrr64_pkg::S_DONE: begin
                r_cnt <= '0;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

endmodule
